// ===== hw/rtl/binary_min_heap_queue_defines.svh =====
// Assertion macros shared by the heap queue RTL.
`ifndef BINARY_MIN_HEAP_QUEUE_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define HMQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define HMQ_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/hmq_pkg.sv =====
// Package with codes, defaults and helpers for the heap queue.
`timescale 1ns / 1ps
package hmq_pkg;

	localparam int CAPACITY_DEF  = 1024;
	localparam int KEY_BITS_DEF  = 32;
	localparam int NODE_BITS_MAX = 17;
	localparam int POS_BITS      = $clog2(NODE_BITS_MAX);
	localparam int STATUS_BITS   = 2;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_SIFT   = 1'b1;

	localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

	// Index of the highest set bit, zero for a zero input.
	function automatic logic [POS_BITS-1:0] msb_pos(input logic [NODE_BITS_MAX-1:0] v);
		logic [POS_BITS-1:0] r;
		r = '0;
		for (int i = 0; i < NODE_BITS_MAX; i++) begin
			if (v[i]) begin
				r = POS_BITS'(i);
			end
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/hmq_ifs.sv =====
// Request and response channel interfaces of the heap queue.
`timescale 1ns / 1ps
interface hmq_req_if #(parameter int KW = hmq_pkg::KEY_BITS_DEF);
	logic          valid;
	logic          ready;
	logic          req_type;
	logic [KW-1:0] key_in;

	modport source (output valid, output req_type, output key_in, input ready);
	modport sink (input valid, input req_type, input key_in, output ready);
endinterface

interface hmq_rsp_if #(
	parameter int KW = hmq_pkg::KEY_BITS_DEF,
	parameter int EW = $clog2(hmq_pkg::CAPACITY_DEF + 1)
);
	logic                            valid;
	logic                            ready;
	logic [KW-1:0]                   key_out;
	logic [hmq_pkg::STATUS_BITS-1:0] status;
	logic [EW-1:0]                   entries;

	modport source (output valid, output key_out, output status, output entries, input ready);
	modport sink (input valid, input key_out, input status, input entries, output ready);
endinterface

// ===== hw/rtl/hmq_cell.sv =====
// One heap level: its node store and the insert / sift-down step for that level.
`timescale 1ns / 1ps
`include "binary_min_heap_queue_defines.svh"
module hmq_cell #(
	parameter int LEVEL = 0,
	parameter int CW = 11,
	parameter int KW = 32,
	parameter int DW = 4,
	parameter type tok_t = logic,
	parameter type upw_t = logic,
	parameter type prb_t = logic
) (
	input  logic          clk,
	input  logic          arst_n,
	input  tok_t          tok_in,
	output tok_t          tok_out,
	input  upw_t          upw_in,
	output upw_t          upw_out,
	input  prb_t          prb,
	output logic [KW-1:0] rd_key,
	output logic          done
);

	// Even and odd banks: the two children of one parent share a row.
	localparam int AW = (LEVEL > 1) ? LEVEL - 1 : 1;
	localparam int BD = 1 << AW;
	localparam int SH = CW - 1 - LEVEL;
	localparam logic [CW-1:0] LBIT = CW'(1) << LEVEL;
	localparam logic [CW-1:0] PBIT = LBIT >> 1;
	localparam logic [DW-1:0] LVL = DW'(LEVEL);

	logic [KW-1:0] mem_e [BD];
	logic [KW-1:0] mem_o [BD];
	logic [KW-1:0] rd_e_q, rd_o_q;
	logic          sel_q;
	logic [AW-1:0] addr_q;
	tok_t          tok_s1;
	tok_t          tok_out_q;

	logic [CW-1:0] ins_node, idx, row, idx_u, row_u;
	logic [AW-1:0] rd_addr, wr_addr, own_addr;
	logic          rd_en, rd_sel, wr_en, wr_sel, own_en, own_sel;
	logic [KW-1:0] wr_key, v, c;
	logic [CW:0]   left, right, lim_x;
	logic          lv, rv, pick_r;
	tok_t          nxt;

	// Read address: token step or a probe from the controller.
	always_comb begin
		ins_node = tok_in.node >> SH;
		idx = '0;
		rd_en = 1'b0;
		if (tok_in.valid) begin
			rd_en = 1'b1;
			if (tok_in.op == hmq_pkg::OP_INSERT) begin
				idx = ins_node ^ LBIT;
			end else begin
				idx = (tok_in.node ^ PBIT) << 1;
			end
		end else if (prb.en) begin
			rd_en = 1'b1;
			// Keep the root in view at the top level.
			idx = (LEVEL == 0) ? CW'(0) : (prb.node ^ LBIT);
		end
		row = idx >> 1;
		rd_addr = row[AW-1:0];
		rd_sel = idx[0];
	end

	assign v = sel_q ? rd_o_q : rd_e_q;
	assign rd_key = v;

	// Step on the read data: place, swap or pass the carried key.
	always_comb begin
		left = {tok_s1.node, 1'b0};
		right = left | (CW + 1)'(1);
		lim_x = {1'b0, tok_s1.lim};
		lv = left <= lim_x;
		rv = right <= lim_x;
		pick_r = rv && (rd_o_q < rd_e_q);
		c = pick_r ? rd_o_q : rd_e_q;
		own_en = 1'b0;
		own_sel = 1'b0;
		own_addr = addr_q;
		nxt = tok_s1;
		nxt.valid = 1'b0;
		upw_out = '0;
		if (tok_s1.valid) begin
			if (tok_s1.op == hmq_pkg::OP_INSERT) begin
				own_sel = sel_q;
				if (tok_s1.depth == LVL) begin
					own_en = 1'b1;
				end else begin
					nxt.valid = 1'b1;
					if (tok_s1.key < v) begin
						own_en = 1'b1;
						nxt.key = v;
					end
				end
			end else if (LEVEL == 0) begin
				// Drop the last key into the root and start the walk down.
				own_en = 1'b1;
				own_addr = '0;
				nxt.valid = 1'b1;
				nxt.node = CW'(1);
			end else if (lv && (c < tok_s1.key)) begin
				own_en = 1'b1;
				own_sel = pick_r;
				nxt.valid = 1'b1;
				nxt.node = left[CW-1:0] | CW'(pick_r);
				upw_out.en = 1'b1;
				upw_out.node = tok_s1.node;
				upw_out.key = c;
			end
		end
	end

	assign done = tok_s1.valid && !nxt.valid;

	// Writes from the level below take the same port as this level's own write.
	always_comb begin
		idx_u = upw_in.node ^ LBIT;
		row_u = idx_u >> 1;
		wr_en = own_en || upw_in.en;
		if (upw_in.en) begin
			wr_addr = row_u[AW-1:0];
			wr_sel = idx_u[0];
			wr_key = upw_in.key;
		end else begin
			wr_addr = own_addr;
			wr_sel = own_sel;
			wr_key = tok_s1.key;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && !wr_sel) begin
			mem_e[wr_addr] <= wr_key;
		end
		if (rd_en) begin
			rd_e_q <= mem_e[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && wr_sel) begin
			mem_o[wr_addr] <= wr_key;
		end
		if (rd_en) begin
			rd_o_q <= mem_o[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			sel_q <= rd_sel;
			addr_q <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			tok_out_q <= '0;
		end else begin
			tok_s1 <= tok_in;
			tok_out_q <= nxt;
		end
	end

	assign tok_out = tok_out_q;

	`HMQ_NEVER(a_tok_probe, tok_in.valid && prb.en, "token and probe in the same cycle")
	`HMQ_NEVER(a_wr_clash, own_en && upw_in.en, "own write collides with write from below")
	`HMQ_ASSERT(a_one_token, tok_in.valid |-> !tok_s1.valid, "two tokens in one cell")

endmodule

// ===== hw/rtl/binary_min_heap_queue.sv =====
// Binary min-heap priority queue built as a chain of per-level cells.
// Usage:
//   req channel: req_type (0 insert key_in, 1 remove minimum) and key_in.
//   rsp channel: key_out, status (ok / full / empty) and entries held after the request.
//   One response per request, in request order. One request is in work at a time.
// Flow:
//   a request that moves no key (full insert, empty removal, last key removed) goes
//   straight to its response; otherwise the key walks the cell chain one level at a
//   time (store read, then compare and write), so a deep insert or sift-down walks
//   the most levels.
//   A new request is taken once the previous response sits in the output register.
// Reset clears the entry count and the control state; the node stores are not
// cleared, since only nodes up to the count are ever read.
// Receiver stall: the response holds in its register; the next request may still be
// taken and worked on, and its response waits until the register frees up.
`timescale 1ns / 1ps
`include "binary_min_heap_queue_defines.svh"
module binary_min_heap_queue #(
	parameter int CAPACITY = hmq_pkg::CAPACITY_DEF,
	parameter int KEY_BITS = hmq_pkg::KEY_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	hmq_req_if.sink    req,
	hmq_rsp_if.source  rsp
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int DW = $clog2(CW);
	localparam int KW = KEY_BITS;
	localparam int NB = hmq_pkg::NODE_BITS_MAX;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PROBE = 3'd1;
	localparam logic [2:0] S_CALC  = 3'd2;
	localparam logic [2:0] S_RUN   = 3'd3;
	localparam logic [2:0] S_RESP  = 3'd4;

	typedef struct packed {
		logic          valid;
		logic          op;
		logic [KW-1:0] key;
		logic [CW-1:0] node;
		logic [DW-1:0] depth;
		logic [CW-1:0] lim;
	} tok_t;

	typedef struct packed {
		logic          en;
		logic [CW-1:0] node;
		logic [KW-1:0] key;
	} upw_t;

	typedef struct packed {
		logic          en;
		logic [CW-1:0] node;
	} prb_t;

	logic [2:0]                      state_q;
	logic                            req_q;
	logic [KW-1:0]                   key_q;
	logic [CW-1:0]                   count_q;
	logic [DW-1:0]                   dlast_q, dins_q;
	logic [CW-1:0]                   mal_q;
	logic [KW-1:0]                   res_key_q;
	logic [hmq_pkg::STATUS_BITS-1:0] res_st_q;
	tok_t                            tok0_q;
	logic                            out_valid_q;
	logic [KW-1:0]                   out_key_q;
	logic [hmq_pkg::STATUS_BITS-1:0] out_st_q;
	logic [CW-1:0]                   out_ent_q;

	tok_t          tok [CW+1];
	upw_t          upw [CW+1];
	prb_t          prb;
	logic [KW-1:0] rdk [CW];
	logic [CW-1:0] done_v;
	logic          chain_done;

	logic [hmq_pkg::POS_BITS-1:0] pos_last, pos_ins;
	logic [CW-1:0]                m_ins;
	logic [KW-1:0]                root, last;

	assign m_ins = count_q + CW'(1);
	assign pos_last = hmq_pkg::msb_pos(NB'(count_q));
	assign pos_ins = hmq_pkg::msb_pos(NB'(m_ins));
	assign root = rdk[0];
	assign last = rdk[dlast_q];

	// Probe reads the root and the last node in the same cycle.
	assign prb.en = (state_q == S_PROBE);
	assign prb.node = count_q;

	assign tok[0] = tok0_q;
	assign upw[CW] = '0;
	assign chain_done = (|done_v) || tok[CW].valid;

	for (genvar g = 0; g < CW; g++) begin : g_lvl
		hmq_cell #(
			.LEVEL(g),
			.CW(CW),
			.KW(KW),
			.DW(DW),
			.tok_t(tok_t),
			.upw_t(upw_t),
			.prb_t(prb_t)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.tok_in(tok[g]),
			.tok_out(tok[g+1]),
			.upw_in(upw[g+1]),
			.upw_out(upw[g]),
			.prb(prb),
			.rd_key(rdk[g]),
			.done(done_v[g])
		);
	end

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.key_out = out_key_q;
	assign rsp.status = out_st_q;
	assign rsp.entries = out_ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			req_q <= hmq_pkg::REQ_INSERT;
			key_q <= '0;
			count_q <= '0;
			dlast_q <= '0;
			dins_q <= '0;
			mal_q <= '0;
			res_key_q <= '0;
			res_st_q <= hmq_pkg::STATUS_OK;
			tok0_q <= '0;
			out_valid_q <= 1'b0;
			out_key_q <= '0;
			out_st_q <= hmq_pkg::STATUS_OK;
			out_ent_q <= '0;
		end else begin
			tok0_q.valid <= 1'b0;
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						req_q <= req.req_type;
						key_q <= req.key_in;
						state_q <= S_PROBE;
					end
				end
				S_PROBE: begin
					dlast_q <= pos_last[DW-1:0];
					dins_q <= pos_ins[DW-1:0];
					// Left-align the new node number so each level takes its ancestor by a fixed shift.
					mal_q <= m_ins << (DW'(CW - 1) - pos_ins[DW-1:0]);
					state_q <= S_CALC;
				end
				S_CALC: begin
					if (req_q == hmq_pkg::REQ_INSERT) begin
						if (count_q == CW'(CAPACITY)) begin
							res_key_q <= root;
							res_st_q <= hmq_pkg::STATUS_FULL;
							state_q <= S_RESP;
						end else begin
							res_key_q <= ((count_q == '0) || (key_q < root)) ? key_q : root;
							res_st_q <= hmq_pkg::STATUS_OK;
							count_q <= m_ins;
							tok0_q.valid <= 1'b1;
							tok0_q.op <= hmq_pkg::OP_INSERT;
							tok0_q.key <= key_q;
							tok0_q.node <= mal_q;
							tok0_q.depth <= dins_q;
							tok0_q.lim <= m_ins;
							state_q <= S_RUN;
						end
					end else begin
						if (count_q == '0) begin
							res_key_q <= '0;
							res_st_q <= hmq_pkg::STATUS_EMPTY;
							state_q <= S_RESP;
						end else begin
							res_key_q <= root;
							res_st_q <= hmq_pkg::STATUS_OK;
							count_q <= count_q - CW'(1);
							if (count_q > CW'(1)) begin
								tok0_q.valid <= 1'b1;
								tok0_q.op <= hmq_pkg::OP_SIFT;
								tok0_q.key <= last;
								tok0_q.node <= CW'(1);
								tok0_q.depth <= '0;
								tok0_q.lim <= count_q - CW'(1);
								state_q <= S_RUN;
							end else begin
								state_q <= S_RESP;
							end
						end
					end
				end
				S_RUN: begin
					if (chain_done) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					// Hold until the output register is free or being drained.
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						out_key_q <= res_key_q;
						out_st_q <= res_st_q;
						out_ent_q <= count_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`HMQ_ASSERT(a_cnt_cap, count_q <= CW'(CAPACITY), "entry count above capacity")
	`HMQ_ASSERT(a_done_run, chain_done |-> (state_q == S_RUN), "chain finished outside run")
	`HMQ_NEVER(a_root_upw, upw[0].en, "root level issued a write upward")
	`HMQ_ASSERT(a_accept_probe, (req.valid && req.ready) |=> (state_q == S_PROBE), "transfer without probe")

endmodule
